@@ sv/owrs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owrs_pkg
// shared types, codes and the crc-8 helper for the rom search core
// ----------------------------------------------------------------------------
package owrs_pkg;

	localparam int unsigned RomW  = 64;
	localparam int unsigned PosW  = 7;
	localparam int unsigned FamW  = 4;
	localparam int unsigned FlagW = 12;

	localparam logic [PosW-1:0] LastBitPos  = 7'd64;
	localparam logic [PosW-1:0] DonePos     = 7'd65;
	localparam logic [PosW-1:0] FamilyLimit = 7'd9;
	localparam logic [7:0]      CrcPoly     = 8'h8C;

	typedef enum logic [2:0] {
		OP_START_FIRST   = 3'd0,
		OP_START_NEXT    = 3'd1,
		OP_PRESENCE      = 3'd2,
		OP_BIT_PAIR      = 3'd3,
		OP_START_VERIFY  = 3'd4,
		OP_TARGET_FAMILY = 3'd5,
		OP_FAMILY_SKIP   = 3'd6
	} op_t;

	typedef enum logic [2:0] {
		ST_ACK       = 3'd0,
		ST_RESET_CMD = 3'd1,
		ST_WRITE     = 3'd2,
		ST_WRITE_FIN = 3'd3,
		ST_FINISHED  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_PRES = 2'd1,
		PH_BITS = 2'd2
	} phase_t;

	typedef struct packed {
		op_t        op;
		logic       presence_seen;
		logic       id_bit;
		logic       complement_bit;
		logic [7:0] family_byte;
	} item_t;

	typedef struct packed {
		status_t         status;
		logic            direction_bit;
		logic            found;
		logic [RomW-1:0] rom_code;
		logic            last_device;
	} result_t;

	typedef struct packed {
		logic [RomW-1:0]  rom_bits;
		logic [PosW-1:0]  last_disc;
		logic [FamW-1:0]  fam_disc;
		logic             last_dev;
		logic [PosW-1:0]  bit_pos;
		logic [PosW-1:0]  recent_zero;
		logic [7:0]       crc;
		phase_t           phase;
		logic             verify;
		logic [RomW-1:0]  saved_rom;
		logic [FlagW-1:0] saved_flags;
	} state_t;

	// dallas crc-8, lsb first, one byte
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
		end
		return c;
	endfunction

endpackage

@@ sv/owrs_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owrs_step
// next-state and result logic for one command of the rom search
// ----------------------------------------------------------------------------
module owrs_step import owrs_pkg::*; (
	input  state_t  cur,
	input  item_t   item,
	output state_t  nxt,
	output result_t res
);

	typedef struct packed {
		state_t s;
		logic   found;
	} fin_t;

	function automatic state_t restore(input state_t s);
		state_t o;
		o           = s;
		o.rom_bits  = s.saved_rom;
		o.last_disc = s.saved_flags[6:0];
		o.fam_disc  = s.saved_flags[10:7];
		o.last_dev  = s.saved_flags[11];
		o.verify    = 1'b0;
		return o;
	endfunction

	function automatic fin_t finish(input state_t s, input logic complete);
		fin_t f;
		f.s     = s;
		f.found = 1'b0;
		if (complete && f.s.crc == 8'd0) begin
			f.s.last_disc = f.s.recent_zero;
			if (f.s.recent_zero == '0) f.s.last_dev = 1'b1;
			f.found = 1'b1;
		end
		if (!f.found || f.s.rom_bits[7:0] == 8'd0) begin
			f.s.last_disc = '0;
			f.s.last_dev  = 1'b0;
			f.s.fam_disc  = '0;
			f.found       = 1'b0;
		end
		if (f.s.verify) begin
			f.found = f.found && (f.s.rom_bits == f.s.saved_rom);
			f.s     = restore(f.s);
		end
		f.s.phase = PH_IDLE;
		return f;
	endfunction

	always_comb begin
		state_t          s;
		fin_t            f;
		logic [PosW-1:0] pos;
		logic [5:0]      idx;
		logic            dir;
		s   = cur;
		f   = '{s: cur, found: 1'b0};
		pos = cur.bit_pos;
		idx = 6'(pos - 7'd1);
		dir = 1'b0;
		res = '{status: ST_ACK, direction_bit: 1'b0, found: 1'b0,
			rom_code: '0, last_device: 1'b0};

		// abandon a running search on any start command
		if (item.op == OP_START_FIRST || item.op == OP_START_NEXT ||
		    item.op == OP_START_VERIFY) begin
			if (s.phase != PH_IDLE && s.verify) s = restore(s);
			s.verify = 1'b0;
			s.phase  = PH_IDLE;
		end

		unique case (item.op)
			OP_START_FIRST, OP_START_NEXT, OP_START_VERIFY: begin
				if (item.op == OP_START_FIRST) begin
					s.last_disc = '0;
					s.last_dev  = 1'b0;
					s.fam_disc  = '0;
				end
				if (item.op == OP_START_VERIFY) begin
					s.saved_rom   = s.rom_bits;
					s.saved_flags = {s.last_dev, s.fam_disc, s.last_disc};
					s.last_disc   = LastBitPos;
					s.last_dev    = 1'b0;
					s.verify      = 1'b1;
				end
				s.bit_pos     = 7'd1;
				s.recent_zero = '0;
				s.crc         = 8'd0;
				if (s.last_dev) begin
					f          = finish(s, 1'b0);
					s          = f.s;
					res.status = ST_FINISHED;
					res.found  = f.found;
				end else begin
					s.phase    = PH_PRES;
					res.status = ST_RESET_CMD;
				end
			end
			OP_PRESENCE: begin
				if (s.phase == PH_PRES) begin
					if (item.presence_seen) begin
						s.phase = PH_BITS;
					end else begin
						f          = finish(s, 1'b0);
						s          = f.s;
						res.status = ST_FINISHED;
						res.found  = f.found;
					end
				end
			end
			OP_BIT_PAIR: begin
				if (s.phase == PH_BITS) begin
					if (item.id_bit && item.complement_bit) begin
						f          = finish(s, 1'b0);
						s          = f.s;
						res.status = ST_FINISHED;
						res.found  = f.found;
					end else begin
						if (item.id_bit != item.complement_bit) begin
							dir = item.id_bit;
						end else begin
							if (pos < s.last_disc) dir = s.rom_bits[idx];
							else                   dir = (pos == s.last_disc);
							if (!dir) begin
								s.recent_zero = pos;
								if (pos < FamilyLimit) s.fam_disc = pos[FamW-1:0];
							end
						end
						s.rom_bits[idx] = dir;
						// close a byte on every eighth bit
						if (pos[2:0] == 3'd0)
							s.crc = crc8_byte(s.crc, s.rom_bits[{idx[5:3], 3'd0} +: 8]);
						s.bit_pos         = pos + 7'd1;
						res.direction_bit = dir;
						if (s.bit_pos >= DonePos) begin
							f          = finish(s, 1'b1);
							s          = f.s;
							res.status = ST_WRITE_FIN;
							res.found  = f.found;
						end else begin
							res.status = ST_WRITE;
						end
					end
				end
			end
			OP_TARGET_FAMILY: begin
				if (s.phase == PH_IDLE) begin
					s.rom_bits  = {56'd0, item.family_byte};
					s.last_disc = LastBitPos;
					s.fam_disc  = '0;
					s.last_dev  = 1'b0;
				end
			end
			OP_FAMILY_SKIP: begin
				if (s.phase == PH_IDLE) begin
					s.last_disc = {3'd0, s.fam_disc};
					s.fam_disc  = '0;
					if (s.last_disc == '0) s.last_dev = 1'b1;
				end
			end
			default: begin
			end
		endcase

		res.rom_code    = s.rom_bits;
		res.last_device = s.last_dev;
		nxt             = s;
	end

endmodule

@@ sv/one_wire_rom_search.sv @@
`timescale 1ns / 1ps
// a transferred command waits in the input stage, then its result is registered in the output register
// throughput: one command per cycle while results are taken, the search state updates in a single step
// the input stage lets a new command in while a result waits to be taken
// reset: search state cleared, bit position one, phase idle, both stages empty
// ----------------------------------------------------------------------------
// one_wire_rom_search
// decision core of the 1-wire rom search: direction bits, crc and verify
// ----------------------------------------------------------------------------
module one_wire_rom_search import owrs_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	// command channel
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [2:0]      operation,
	input  logic            presence_seen,
	input  logic            id_bit,
	input  logic            complement_bit,
	input  logic [7:0]      family_byte,
	// result channel
	output logic            out_valid,
	input  logic            out_ready,
	output logic [2:0]      status,
	output logic            direction_bit,
	output logic            found,
	output logic [RomW-1:0] rom_code,
	output logic            last_device
);

	// input stage
	logic    valid_s1;
	item_t   item_s1;

	// search state
	state_t  state_q;
	state_t  state_nxt;

	// result register
	logic    out_valid_q;
	result_t res_q;
	result_t res_nxt;

	logic    fire;

	// the input stage moves on when the result register is empty or draining
	assign fire     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;

	owrs_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// control and search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '{rom_bits: '0, last_disc: '0, fam_disc: '0, last_dev: 1'b0,
				bit_pos: 7'd1, recent_zero: '0, crc: 8'd0, phase: PH_IDLE,
				verify: 1'b0, saved_rom: '0, saved_flags: '0};
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (fire) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= '{op: op_t'(operation), presence_seen: presence_seen,
				id_bit: id_bit, complement_bit: complement_bit,
				family_byte: family_byte};
		end
		if (fire) res_q <= res_nxt;
	end

	assign out_valid     = out_valid_q;
	assign status        = res_q.status;
	assign direction_bit = res_q.direction_bit;
	assign found         = res_q.found;
	assign rom_code      = res_q.rom_code;
	assign last_device   = res_q.last_device;

	// bit position stays within the rom while bit pairs are taken
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_BITS |-> (state_q.bit_pos >= 7'd1 && state_q.bit_pos <= LastBitPos))
		else $error("bit position out of range during search");

	// verify mode only lives inside a running search
	a_verify_phase: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.verify |-> state_q.phase != PH_IDLE)
		else $error("verify mode left set while idle");

	// a processed command always lands in the result register
	a_fire_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("result lost after processing");

	// direction only with a write status, found only with a finished status
	a_result_codes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((!res_q.direction_bit || res_q.status == ST_WRITE ||
		res_q.status == ST_WRITE_FIN) && (!res_q.found ||
		res_q.status == ST_WRITE_FIN || res_q.status == ST_FINISHED)))
		else $error("result flags inconsistent with status");

endmodule
